// ===== rtl/dpcp_pkg.sv =====
// Shared types, command codes and action codes for the debug probe command parser.
package dpcp_pkg;

   localparam int SEQ_BYTES = 32;
   localparam int SEQ_AW    = $clog2(SEQ_BYTES);
   localparam int SEQ_CW    = $clog2(SEQ_BYTES + 1);

   localparam logic [31:0] PIN_WAIT_MAX = 32'd3000000;

   localparam logic [7:0] CMD_INFO       = 8'h00;
   localparam logic [7:0] CMD_HOST_STAT  = 8'h01;
   localparam logic [7:0] CMD_CONNECT    = 8'h02;
   localparam logic [7:0] CMD_DISCONNECT = 8'h03;
   localparam logic [7:0] CMD_ABORT      = 8'h08;
   localparam logic [7:0] CMD_DELAY      = 8'h09;
   localparam logic [7:0] CMD_RESET_TGT  = 8'h0A;
   localparam logic [7:0] CMD_PINS       = 8'h10;
   localparam logic [7:0] CMD_CLOCK      = 8'h11;
   localparam logic [7:0] CMD_SEQUENCE   = 8'h12;

   localparam logic [3:0] ACT_INVALID  = 4'd0;
   localparam logic [3:0] ACT_UNDEF    = 4'd1;
   localparam logic [3:0] ACT_INFO     = 4'd2;
   localparam logic [3:0] ACT_CONNSTAT = 4'd3;
   localparam logic [3:0] ACT_RUNSTAT  = 4'd4;
   localparam logic [3:0] ACT_SWD      = 4'd5;
   localparam logic [3:0] ACT_JTAG     = 4'd6;
   localparam logic [3:0] ACT_DISC     = 4'd7;
   localparam logic [3:0] ACT_ABORT    = 4'd8;
   localparam logic [3:0] ACT_DELAY    = 4'd9;
   localparam logic [3:0] ACT_RESET    = 4'd10;
   localparam logic [3:0] ACT_PINS     = 4'd11;
   localparam logic [3:0] ACT_CLOCK    = 4'd12;
   localparam logic [3:0] ACT_SEQUENCE = 4'd13;

   localparam logic [7:0] HOST_STAT_CONNECT = 8'd0;
   localparam logic [7:0] HOST_STAT_RUNNING = 8'd1;
   localparam logic [7:0] CONN_DEFAULT      = 8'd0;
   localparam logic [7:0] CONN_SWD          = 8'd1;
   localparam logic [7:0] CONN_JTAG         = 8'd2;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       packet_end;
   } req_type;

   typedef struct packed {
      logic [3:0]  action;
      logic        port_is_jtag;
      logic        host_connected;
      logic        host_running;
      logic [7:0]  arg_byte_a;
      logic [7:0]  arg_byte_b;
      logic [31:0] arg_word;
      logic [7:0]  seq_data;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic stage;
      logic load_head;
      logic load_seq;
   } cmd_type;

   typedef struct packed {
      logic head_has_seq;
      logic seq_last;
   } sts_type;

endpackage

// ===== rtl/dpcp_ctrl.sv =====
// Controller state machine: byte intake, decode slot and sequence replay.
module dpcp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_end,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dpcp_pkg::cmd_type cmd,
   input  dpcp_pkg::sts_type sts
);

   localparam logic [1:0] S_BYTE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_SEQ    = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_BYTE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.stage     = accept;
      cmd.load_head = 1'b0;
      cmd.load_seq  = 1'b0;
      case (state_ff)
         S_BYTE: begin
            if (accept && req_end) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (out_free) begin
               cmd.load_head = 1'b1;
               state_in      = sts.head_has_seq ? S_SEQ : S_BYTE;
            end
         end
         S_SEQ: begin
            if (out_free) begin
               cmd.load_seq = 1'b1;
               if (sts.seq_last) state_in = S_BYTE;
            end
         end
         default: state_in = S_BYTE;
      endcase
      if (cmd.load_head || cmd.load_seq) rsp_valid_in = 1'b1;
      else if (rsp_ready)                rsp_valid_in = 1'b0;
      else                               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BYTE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_end_to_decode: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end) |=> (state_ff == S_DECODE))
      else $error("final byte did not enter decode");

   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_head || cmd.load_seq) |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_seq_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_seq && sts.seq_last) |=> (state_ff == S_BYTE))
      else $error("replay did not return to intake");

   a_no_intake_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEQ || state_ff == S_DECODE) |-> !accept)
      else $error("request taken during decode or replay");

endmodule

// ===== rtl/dpcp_datapath.sv =====
// Datapath: staging registers, sequence buffer, decode, stored registers, result register.
module dpcp_datapath (
   input  logic              clock,
   input  logic              reset,
   input  dpcp_pkg::req_type req_data,
   input  logic              csr_valid,
   input  logic              csr_default_port_jtag,
   input  dpcp_pkg::cmd_type cmd,
   output dpcp_pkg::sts_type sts,
   output dpcp_pkg::rsp_type rsp_data
);

   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  command_id_ff;
   logic [7:0]  staged_a_ff;
   logic [7:0]  staged_b_ff;
   logic [31:0] staged_word_ff;
   logic        default_port_ff;

   logic [7:0]  info_id_ff, info_id_in;
   logic        connect_ff, connect_in;
   logic        running_ff, running_in;
   logic        jtag_ff, jtag_in;
   logic [7:0]  ap_index_ff, ap_index_in;
   logic [31:0] abort_ff, abort_in;
   logic [15:0] delay_ff, delay_in;
   logic [7:0]  pin_out_ff, pin_out_in;
   logic [7:0]  pin_sel_ff, pin_sel_in;
   logic [31:0] pin_wait_ff, pin_wait_in;
   logic [31:0] clock_rate_ff, clock_rate_in;
   logic [7:0]  seq_bits_ff, seq_bits_in;

   logic [7:0]  seq_mem [dpcp_pkg::SEQ_BYTES];
   logic [dpcp_pkg::SEQ_AW-1:0] seq_idx_ff, seq_idx_in;
   logic [dpcp_pkg::SEQ_CW-1:0] nseq_ff, nseq_in;
   logic [7:0]  rd_data_ff;
   logic        mem_we;
   logic [dpcp_pkg::SEQ_AW-1:0] mem_waddr;
   logic [7:0]  pos_off;

   logic [3:0]  act;
   logic [dpcp_pkg::SEQ_CW-1:0] nb;
   logic [7:0]  sel_a, sel_b;
   logic [31:0] sel_w;

   dpcp_pkg::rsp_type rsp_ff;

   assign pos_off   = byte_count_ff - 8'd2;
   assign mem_we    = cmd.stage && (byte_count_ff >= 8'd2)
                      && (pos_off < 8'(dpcp_pkg::SEQ_BYTES));
   assign mem_waddr = pos_off[dpcp_pkg::SEQ_AW-1:0];
   assign byte_count_in = (byte_count_ff == 8'hFF) ? byte_count_ff : byte_count_ff + 8'd1;

   // bit count 0 means a full buffer
   assign nb = (staged_a_ff == 8'd0) ? dpcp_pkg::SEQ_CW'(dpcp_pkg::SEQ_BYTES)
             : dpcp_pkg::SEQ_CW'(({1'b0, staged_a_ff} + 9'd7) >> 3);

   always_comb begin
      act           = dpcp_pkg::ACT_INVALID;
      nseq_in       = '0;
      info_id_in    = info_id_ff;
      connect_in    = connect_ff;
      running_in    = running_ff;
      jtag_in       = jtag_ff;
      ap_index_in   = ap_index_ff;
      abort_in      = abort_ff;
      delay_in      = delay_ff;
      pin_out_in    = pin_out_ff;
      pin_sel_in    = pin_sel_ff;
      pin_wait_in   = pin_wait_ff;
      clock_rate_in = clock_rate_ff;
      seq_bits_in   = seq_bits_ff;
      case (command_id_ff)
         dpcp_pkg::CMD_INFO: begin
            if (byte_count_ff == 8'd2) begin
               info_id_in = staged_a_ff;
               act        = dpcp_pkg::ACT_INFO;
            end
         end
         dpcp_pkg::CMD_HOST_STAT: begin
            if (byte_count_ff == 8'd3) begin
               if (staged_a_ff == dpcp_pkg::HOST_STAT_CONNECT) begin
                  connect_in = (staged_b_ff != 8'd0);
                  act        = dpcp_pkg::ACT_CONNSTAT;
               end else if (staged_a_ff == dpcp_pkg::HOST_STAT_RUNNING) begin
                  running_in = (staged_b_ff != 8'd0);
                  act        = dpcp_pkg::ACT_RUNSTAT;
               end
            end
         end
         dpcp_pkg::CMD_CONNECT: begin
            if (byte_count_ff == 8'd2) begin
               if (staged_a_ff == dpcp_pkg::CONN_DEFAULT) begin
                  jtag_in = default_port_ff;
                  act     = default_port_ff ? dpcp_pkg::ACT_JTAG : dpcp_pkg::ACT_SWD;
               end else if (staged_a_ff == dpcp_pkg::CONN_SWD) begin
                  jtag_in = 1'b0;
                  act     = dpcp_pkg::ACT_SWD;
               end else if (staged_a_ff == dpcp_pkg::CONN_JTAG) begin
                  jtag_in = 1'b1;
                  act     = dpcp_pkg::ACT_JTAG;
               end
            end
         end
         dpcp_pkg::CMD_DISCONNECT: act = dpcp_pkg::ACT_DISC;
         dpcp_pkg::CMD_ABORT: begin
            if (byte_count_ff == 8'd6) begin
               ap_index_in = staged_a_ff;
               abort_in    = staged_word_ff;
               act         = dpcp_pkg::ACT_ABORT;
            end
         end
         dpcp_pkg::CMD_DELAY: begin
            if (byte_count_ff == 8'd3) begin
               delay_in = staged_word_ff[31:16];
               act      = dpcp_pkg::ACT_DELAY;
            end
         end
         dpcp_pkg::CMD_RESET_TGT: act = dpcp_pkg::ACT_RESET;
         dpcp_pkg::CMD_PINS: begin
            if (byte_count_ff == 8'd7 && staged_word_ff <= dpcp_pkg::PIN_WAIT_MAX) begin
               pin_out_in  = staged_a_ff;
               pin_sel_in  = staged_b_ff;
               pin_wait_in = staged_word_ff;
               act         = dpcp_pkg::ACT_PINS;
            end
         end
         dpcp_pkg::CMD_CLOCK: begin
            if (byte_count_ff == 8'd5) begin
               clock_rate_in = staged_word_ff;
               act           = dpcp_pkg::ACT_CLOCK;
            end
         end
         dpcp_pkg::CMD_SEQUENCE: begin
            if (byte_count_ff >= 8'd3
                && {1'b0, byte_count_ff} == 9'd2 + 9'(nb)) begin
               seq_bits_in = staged_a_ff;
               nseq_in     = nb;
               act         = dpcp_pkg::ACT_SEQUENCE;
            end
         end
         default: act = dpcp_pkg::ACT_UNDEF;
      endcase

      sel_a = 8'd0;
      sel_b = 8'd0;
      sel_w = 32'd0;
      case (act)
         dpcp_pkg::ACT_INFO:     sel_a = info_id_in;
         dpcp_pkg::ACT_ABORT: begin
            sel_a = ap_index_in;
            sel_w = abort_in;
         end
         dpcp_pkg::ACT_DELAY:    sel_w = {16'd0, delay_in};
         dpcp_pkg::ACT_PINS: begin
            sel_a = pin_out_in;
            sel_b = pin_sel_in;
            sel_w = pin_wait_in;
         end
         dpcp_pkg::ACT_CLOCK:    sel_w = clock_rate_in;
         dpcp_pkg::ACT_SEQUENCE: sel_a = seq_bits_in;
         default: ;
      endcase

      if (cmd.load_head)     seq_idx_in = '0;
      else if (cmd.load_seq) seq_idx_in = seq_idx_ff + 1'b1;
      else                   seq_idx_in = seq_idx_ff;
   end

   assign sts.head_has_seq = (nseq_in != '0);
   assign sts.seq_last     = ({1'b0, seq_idx_ff} + 1'b1) == nseq_ff;
   assign rsp_data         = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) seq_mem[mem_waddr] <= req_data.packet_byte;
      rd_data_ff <= seq_mem[seq_idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= 8'd0;
         command_id_ff   <= 8'd0;
         staged_a_ff     <= 8'd0;
         staged_b_ff     <= 8'd0;
         staged_word_ff  <= 32'd0;
         default_port_ff <= 1'b0;
         info_id_ff      <= 8'd1;
         connect_ff      <= 1'b0;
         running_ff      <= 1'b0;
         jtag_ff         <= 1'b0;
         ap_index_ff     <= 8'd0;
         abort_ff        <= 32'd0;
         delay_ff        <= 16'd0;
         pin_out_ff      <= 8'd0;
         pin_sel_ff      <= 8'd0;
         pin_wait_ff     <= 32'd0;
         clock_rate_ff   <= 32'd0;
         seq_bits_ff     <= 8'd0;
         seq_idx_ff      <= '0;
         nseq_ff         <= '0;
      end else begin
         if (csr_valid) default_port_ff <= csr_default_port_jtag;
         if (cmd.stage) begin
            if (byte_count_ff == 8'd0) command_id_ff <= req_data.packet_byte;
            if (byte_count_ff == 8'd1) staged_a_ff   <= req_data.packet_byte;
            if (byte_count_ff == 8'd2) staged_b_ff   <= req_data.packet_byte;
            staged_word_ff <= {req_data.packet_byte, staged_word_ff[31:8]};
            byte_count_ff  <= byte_count_in;
         end
         if (cmd.load_head) begin
            byte_count_ff <= 8'd0;
            info_id_ff    <= info_id_in;
            connect_ff    <= connect_in;
            running_ff    <= running_in;
            jtag_ff       <= jtag_in;
            ap_index_ff   <= ap_index_in;
            abort_ff      <= abort_in;
            delay_ff      <= delay_in;
            pin_out_ff    <= pin_out_in;
            pin_sel_ff    <= pin_sel_in;
            pin_wait_ff   <= pin_wait_in;
            clock_rate_ff <= clock_rate_in;
            seq_bits_ff   <= seq_bits_in;
            nseq_ff       <= nseq_in;
         end
         seq_idx_ff <= seq_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_head) begin
         rsp_ff.action         <= act;
         rsp_ff.port_is_jtag   <= jtag_in;
         rsp_ff.host_connected <= connect_in;
         rsp_ff.host_running   <= running_in;
         rsp_ff.arg_byte_a     <= sel_a;
         rsp_ff.arg_byte_b     <= sel_b;
         rsp_ff.arg_word       <= sel_w;
         rsp_ff.seq_data       <= 8'd0;
         rsp_ff.run_last       <= (nseq_in == '0);
      end else if (cmd.load_seq) begin
         rsp_ff.seq_data <= rd_data_ff;
         rsp_ff.run_last <= sts.seq_last;
      end
   end

endmodule

// ===== rtl/debug_probe_command_parser.sv =====
// Top level of the debug probe command parser: controller plus datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (packet_byte, packet_end)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (action ... run_last)
//   csr      in         csr_valid / csr_ready  csr_default_port_jtag
//
// Packet bytes are taken one per cycle in the intake state; the final byte is followed by a
// decode state before the next request is taken, and a sequence command replays its bytes.
// A non-sequence result can wait in the output register while the next packet's bytes
// stream in; the next final byte, or a pending replay byte, stalls the input until the
// register frees. Reset is synchronous and sets all control and stored registers to zero,
// but the info id to 1; the sequence buffer has no reset and replay reads only entries that
// the current packet wrote. A stalled result holds its payload until taken.
module debug_probe_command_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dpcp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dpcp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_default_port_jtag
);

   dpcp_pkg::cmd_type cmd;
   dpcp_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   dpcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_end   (req_data.packet_end),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   dpcp_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_data              (req_data),
      .csr_valid             (csr_valid),
      .csr_default_port_jtag (csr_default_port_jtag),
      .cmd                   (cmd),
      .sts                   (sts),
      .rsp_data              (rsp_data)
   );

endmodule

// ===== test/debug_probe_command_parser_tb.sv =====
// Self-checking testbench for the debug probe command parser: packet stimulus, predictor, checker.
module debug_probe_command_parser_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 20;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   dpcp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   dpcp_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_default_port_jtag;

   debug_probe_command_parser uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data              (req_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_data              (rsp_data),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_default_port_jtag (csr_default_port_jtag)
   );

   // request bytes waiting to be driven, and results still owed by the block
   dpcp_pkg::req_type byte_q[$];
   dpcp_pkg::rsp_type reply_q[$];
   logic [7:0]        pkt[$];
   dpcp_pkg::rsp_type oldest;
   int          bytes_queued;
   int          bytes_taken;
   int          error_count;
   int          cycle_count;
   logic        req_fire;
   logic        calm;
   int          send_gap;
   int          stall_left;
   int          hold_left;
   int          holds_asked;
   int          holds_done;

   // predictor state
   logic        port_default;
   logic [7:0]  byte_cnt;
   logic [7:0]  cmd_id;
   logic [7:0]  stage_a;
   logic [7:0]  stage_b;
   logic [31:0] stage_word;
   logic [7:0]  stage_seq [dpcp_pkg::SEQ_BYTES];
   logic [7:0]  info_r;
   logic        conn_r;
   logic        run_r;
   logic        jtag_r;
   logic [7:0]  ap_r;
   logic [31:0] abort_r;
   logic [15:0] delay_r;
   logic [7:0]  pout_r;
   logic [7:0]  psel_r;
   logic [31:0] pwait_r;
   logic [31:0] clk_r;
   logic [7:0]  seqbits_r;
   logic [7:0]  seq_store [dpcp_pkg::SEQ_BYTES];

   always #1 clock = ~clock;

   task automatic parse_packet_byte(input dpcp_pkg::req_type r);
      int                pos;
      int                len;
      int                nseq;
      int                nb;
      logic [3:0]        act;
      dpcp_pkg::rsp_type e;
      pos = int'(byte_cnt);
      if (pos == 0) cmd_id = r.packet_byte;
      else if (pos == 1) stage_a = r.packet_byte;
      else if (pos == 2) stage_b = r.packet_byte;
      if (pos >= 2 && pos - 2 < dpcp_pkg::SEQ_BYTES) stage_seq[pos - 2] = r.packet_byte;
      stage_word = {r.packet_byte, stage_word[31:8]};
      if (byte_cnt != 8'hFF) byte_cnt = byte_cnt + 8'd1;
      if (r.packet_end) begin
         len = int'(byte_cnt);
         byte_cnt = 8'd0;
         nseq = 0;
         act = dpcp_pkg::ACT_INVALID;
         case (cmd_id)
            dpcp_pkg::CMD_INFO: begin
               if (len == 2) begin
                  info_r = stage_a;
                  act = dpcp_pkg::ACT_INFO;
               end
            end
            dpcp_pkg::CMD_HOST_STAT: begin
               if (len == 3 && stage_a == dpcp_pkg::HOST_STAT_CONNECT) begin
                  conn_r = (stage_b != 8'd0);
                  act = dpcp_pkg::ACT_CONNSTAT;
               end else if (len == 3 && stage_a == dpcp_pkg::HOST_STAT_RUNNING) begin
                  run_r = (stage_b != 8'd0);
                  act = dpcp_pkg::ACT_RUNSTAT;
               end
            end
            dpcp_pkg::CMD_CONNECT: begin
               if (len == 2 && stage_a == dpcp_pkg::CONN_DEFAULT) begin
                  jtag_r = port_default;
                  act = port_default ? dpcp_pkg::ACT_JTAG : dpcp_pkg::ACT_SWD;
               end else if (len == 2 && stage_a == dpcp_pkg::CONN_SWD) begin
                  jtag_r = 1'b0;
                  act = dpcp_pkg::ACT_SWD;
               end else if (len == 2 && stage_a == dpcp_pkg::CONN_JTAG) begin
                  jtag_r = 1'b1;
                  act = dpcp_pkg::ACT_JTAG;
               end
            end
            dpcp_pkg::CMD_DISCONNECT: act = dpcp_pkg::ACT_DISC;
            dpcp_pkg::CMD_ABORT: begin
               if (len == 6) begin
                  ap_r = stage_a;
                  abort_r = stage_word;
                  act = dpcp_pkg::ACT_ABORT;
               end
            end
            dpcp_pkg::CMD_DELAY: begin
               if (len == 3) begin
                  delay_r = stage_word[31:16];
                  act = dpcp_pkg::ACT_DELAY;
               end
            end
            dpcp_pkg::CMD_RESET_TGT: act = dpcp_pkg::ACT_RESET;
            dpcp_pkg::CMD_PINS: begin
               if (len == 7 && stage_word <= dpcp_pkg::PIN_WAIT_MAX) begin
                  pout_r = stage_a;
                  psel_r = stage_b;
                  pwait_r = stage_word;
                  act = dpcp_pkg::ACT_PINS;
               end
            end
            dpcp_pkg::CMD_CLOCK: begin
               if (len == 5) begin
                  clk_r = stage_word;
                  act = dpcp_pkg::ACT_CLOCK;
               end
            end
            dpcp_pkg::CMD_SEQUENCE: begin
               nb = (stage_a == 8'd0) ? dpcp_pkg::SEQ_BYTES : (int'(stage_a) + 7) / 8;
               if (len >= 3 && len == 2 + nb) begin
                  seqbits_r = stage_a;
                  for (int i = 0; i < nb; i++) seq_store[i] = stage_seq[i];
                  nseq = nb;
                  act = dpcp_pkg::ACT_SEQUENCE;
               end
            end
            default: act = dpcp_pkg::ACT_UNDEF;
         endcase
         e = '0;
         e.action = act;
         e.port_is_jtag = jtag_r;
         e.host_connected = conn_r;
         e.host_running = run_r;
         case (act)
            dpcp_pkg::ACT_INFO: e.arg_byte_a = info_r;
            dpcp_pkg::ACT_ABORT: begin
               e.arg_byte_a = ap_r;
               e.arg_word = abort_r;
            end
            dpcp_pkg::ACT_DELAY: e.arg_word = {16'd0, delay_r};
            dpcp_pkg::ACT_PINS: begin
               e.arg_byte_a = pout_r;
               e.arg_byte_b = psel_r;
               e.arg_word = pwait_r;
            end
            dpcp_pkg::ACT_CLOCK: e.arg_word = clk_r;
            dpcp_pkg::ACT_SEQUENCE: e.arg_byte_a = seqbits_r;
            default: ;
         endcase
         e.run_last = (nseq == 0);
         reply_q.push_back(e);
         for (int i = 0; i < nseq; i++) begin
            e.seq_data = seq_store[i];
            e.run_last = (i == nseq - 1);
            reply_q.push_back(e);
         end
      end
   endtask

   // checker and predictor feed
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (reply_q.size() == 0) begin
               if (error_count < 10) $display("unexpected result %h", rsp_data);
               error_count++;
            end else begin
               oldest = reply_q.pop_front();
               if (rsp_data !== oldest) begin
                  if (error_count < 10)
                     $display("mismatch: action %0d/%0d exp %h got %h",
                              oldest.action, rsp_data.action, oldest, rsp_data);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            parse_packet_byte(req_data);
            bytes_taken++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (byte_q.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 18) - 1;
            req_valid <= 1'b0;
         end else if (byte_q.size() > 0) begin
            req_data <= byte_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL debug_probe_command_parser");
         $finish;
      end
   end

   task automatic put(input logic [7:0] b);
      pkt.push_back(b);
   endtask

   task automatic put_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) pkt.push_back(w[8*i +: 8]);
   endtask

   task automatic put_random(input int n);
      for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic send_packet();
      dpcp_pkg::req_type r;
      foreach (pkt[i]) begin
         r.packet_byte = pkt[i];
         r.packet_end = (i == pkt.size() - 1);
         byte_q.push_back(r);
      end
      bytes_queued += pkt.size();
      pkt.delete();
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (bytes_taken != bytes_queued || reply_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_port_default(input logic v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_default_port_jtag <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      port_default = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_packet();
      int          nb;
      logic [7:0]  bits;
      logic [31:0] w;
      case ($urandom_range(0, 15))
         0: begin
            put(dpcp_pkg::CMD_INFO);
            put_random(1);
         end
         1: begin
            put(dpcp_pkg::CMD_HOST_STAT);
            put($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 1)));
            put($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
         end
         2: begin
            put(dpcp_pkg::CMD_CONNECT);
            put($urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 3)));
         end
         3: begin
            put(dpcp_pkg::CMD_DISCONNECT);
            put_random($urandom_range(0, 4));
         end
         4: begin
            put(dpcp_pkg::CMD_ABORT);
            put_random(1);
            put_word($urandom);
         end
         5: begin
            put(dpcp_pkg::CMD_DELAY);
            put_random(2);
         end
         6: begin
            put(dpcp_pkg::CMD_RESET_TGT);
            put_random($urandom_range(0, 3));
         end
         7: begin
            case ($urandom_range(0, 3))
               0: w = $urandom_range(0, 3000000);
               1: w = dpcp_pkg::PIN_WAIT_MAX + $urandom_range(0, 1);
               2: w = $urandom;
               default: w = $urandom_range(0, 255);
            endcase
            put(dpcp_pkg::CMD_PINS);
            put_random(2);
            put_word(w);
         end
         8: begin
            put(dpcp_pkg::CMD_CLOCK);
            put_word($urandom);
         end
         9, 10, 11: begin
            bits = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(1, 24));
            nb = (bits == 8'd0) ? dpcp_pkg::SEQ_BYTES : (int'(bits) + 7) / 8;
            put(dpcp_pkg::CMD_SEQUENCE);
            put(bits);
            put_random(nb);
         end
         12: begin
            put(8'($urandom_range(0, 255)));
            put_random($urandom_range(0, 6));
         end
         default: begin
            case ($urandom_range(0, 9))
               0: put(dpcp_pkg::CMD_INFO);
               1: put(dpcp_pkg::CMD_HOST_STAT);
               2: put(dpcp_pkg::CMD_CONNECT);
               3: put(dpcp_pkg::CMD_DISCONNECT);
               4: put(dpcp_pkg::CMD_ABORT);
               5: put(dpcp_pkg::CMD_DELAY);
               6: put(dpcp_pkg::CMD_RESET_TGT);
               7: put(dpcp_pkg::CMD_PINS);
               8: put(dpcp_pkg::CMD_CLOCK);
               default: put(dpcp_pkg::CMD_SEQUENCE);
            endcase
            put_random($urandom_range(0, 8));
         end
      endcase
      send_packet();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_default_port_jtag = 1'b0;
      req_fire = 1'b0;
      calm = 1'b0;
      send_gap = 0;
      stall_left = 0;
      hold_left = 0;
      holds_asked = 0;
      holds_done = 0;
      bytes_queued = 0;
      bytes_taken = 0;
      error_count = 0;
      cycle_count = 0;
      port_default = 1'b0;
      byte_cnt = '0;
      cmd_id = '0;
      stage_a = '0;
      stage_b = '0;
      stage_word = '0;
      info_r = 8'd1;
      conn_r = 1'b0;
      run_r = 1'b0;
      jtag_r = 1'b0;
      ap_r = '0;
      abort_r = '0;
      delay_r = '0;
      pout_r = '0;
      psel_r = '0;
      pwait_r = '0;
      clk_r = '0;
      seqbits_r = '0;
      for (int i = 0; i < dpcp_pkg::SEQ_BYTES; i++) begin
         stage_seq[i] = '0;
         seq_store[i] = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_port_default(1'b0);
      put(dpcp_pkg::CMD_INFO); put(8'hFF); send_packet();
      put(dpcp_pkg::CMD_INFO); send_packet();
      put(dpcp_pkg::CMD_HOST_STAT); put(dpcp_pkg::HOST_STAT_CONNECT); put(8'h80);
      send_packet();
      put(dpcp_pkg::CMD_HOST_STAT); put(dpcp_pkg::HOST_STAT_RUNNING); put(8'h01);
      send_packet();
      put(dpcp_pkg::CMD_HOST_STAT); put(8'h02); put(8'h00); send_packet();
      put(dpcp_pkg::CMD_CONNECT); put(dpcp_pkg::CONN_DEFAULT); send_packet();
      put(dpcp_pkg::CMD_CONNECT); put(dpcp_pkg::CONN_JTAG); send_packet();
      put(dpcp_pkg::CMD_CONNECT); put(dpcp_pkg::CONN_SWD); send_packet();
      put(dpcp_pkg::CMD_CONNECT); put(8'h03); send_packet();
      put(dpcp_pkg::CMD_DISCONNECT); send_packet();
      put(dpcp_pkg::CMD_ABORT); put(8'hFF); put_word(32'hFFFF_FFFF); send_packet();
      put(dpcp_pkg::CMD_DELAY); put(8'hFF); put(8'hFF); send_packet();
      put(dpcp_pkg::CMD_RESET_TGT); send_packet();
      put(dpcp_pkg::CMD_PINS); put(8'hA5); put(8'h5A);
      put_word(dpcp_pkg::PIN_WAIT_MAX); send_packet();
      put(dpcp_pkg::CMD_PINS); put(8'h00); put(8'hFF);
      put_word(dpcp_pkg::PIN_WAIT_MAX + 1); send_packet();
      put(dpcp_pkg::CMD_CLOCK); put_word(32'hFFFF_FFFF); send_packet();
      put(dpcp_pkg::CMD_CLOCK); put_word(32'h0000_0000); send_packet();
      put(dpcp_pkg::CMD_SEQUENCE); put(8'd1); put(8'hFF); send_packet();
      put(dpcp_pkg::CMD_SEQUENCE); put(8'd0); put_random(dpcp_pkg::SEQ_BYTES);
      send_packet();
      put(dpcp_pkg::CMD_SEQUENCE); put(8'd255); put_random(dpcp_pkg::SEQ_BYTES);
      send_packet();
      put(dpcp_pkg::CMD_SEQUENCE); put(8'd9); put(8'h00); send_packet();
      put(dpcp_pkg::CMD_SEQUENCE); send_packet();
      put(8'hFF); put(8'h00); send_packet();

      wait_idle();
      write_port_default(1'b1);
      put(dpcp_pkg::CMD_CONNECT); put(dpcp_pkg::CONN_DEFAULT); send_packet();
      put(dpcp_pkg::CMD_INFO); put(8'h00); send_packet();

      // receiver holds off while the sender keeps offering
      wait_idle();
      holds_asked = holds_asked + 1;
      for (int i = 0; i < 4; i++) random_packet();

      wait_idle();
      write_port_default(1'($urandom_range(0, 1)));
      calm = 1'b1;
      for (int i = 0; i < 3; i++) random_packet();

      wait_idle();
      repeat (40) @(negedge clock);
      error_count += reply_q.size();
      if (error_count == 0) begin
         $display("PASS debug_probe_command_parser");
      end else begin
         $display("FAIL debug_probe_command_parser");
      end
      $finish;
   end

endmodule
